[src/vac_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vac_pkg
// Shared constants for the vibration alarm confirm state machine: phase
// codes, register indexes, field widths, register reset values and the result type.
// ---------------------------------------------------------------------------
package vac_pkg;

    localparam int PHASE_W  = 2;
    localparam int COUNT_W  = 8;
    localparam int TIMER_W  = 16;
    localparam int SINCE_W  = 8;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 16;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_ALARM = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_CONFIRM_WINDOW = 2'd0;
    localparam logic [CFG_AW-1:0] REG_ALARM_DURATION = 2'd1;
    localparam logic [CFG_AW-1:0] REG_DEBOUNCE       = 2'd2;
    localparam logic [CFG_AW-1:0] REG_THRESHOLD      = 2'd3;

    // register reset values
    localparam logic [TIMER_W-1:0] CONFIRM_WINDOW_RST = 16'd500;
    localparam logic [TIMER_W-1:0] ALARM_DURATION_RST = 16'd30000;
    localparam logic [SINCE_W-1:0] DEBOUNCE_RST       = 8'd20;
    localparam logic [COUNT_W-1:0] THRESHOLD_RST      = 8'd3;

    localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [COUNT_W-1:0] pulses_counted;
        logic               alarm_started;
        logic [PHASE_W-1:0] phase;
        logic               alarm_on;
    } result_t;

endpackage

[src/vibration_alarm_confirm_fsm.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vibration_alarm_confirm_fsm
// Debounces vibration pulses, counts them in a confirm window and raises a
// timed alarm if the count has reached the threshold when the window ends. One word is one tick.
// ---------------------------------------------------------------------------
// throughput: one word per cycle; the state update and the result register
// are both written in the accepting cycle, ready drops only on output stall
// reset (aresetn low, synchronous): phase idle, count zero, pulse spacing
// saturated, registers back to window 500, alarm 30000, debounce 20,
// threshold 3, no result pending
module vibration_alarm_confirm_fsm (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [vac_pkg::CFG_AW-1:0]      cfg_wr_addr,
    input  logic [vac_pkg::CFG_DW-1:0]      cfg_wr_data,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vac_pkg::S_DATA_W-1:0]    s_tdata,   // [0] pulse_seen, [7:1] zero
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vac_pkg::M_DATA_W-1:0]    m_tdata    // [0] alarm_on, [2:1] phase,
                                                       // [3] alarm_started,
                                                       // [11:4] pulses_counted,
                                                       // [15:12] zero
);
    import vac_pkg::*;

    logic [TIMER_W-1:0] window_reg;
    logic [TIMER_W-1:0] duration_reg;
    logic [SINCE_W-1:0] debounce_reg;
    logic [COUNT_W-1:0] threshold_reg;

    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [TIMER_W-1:0] timer_reg,  timer_next;
    logic [SINCE_W-1:0] since_reg,  since_next;
    logic               started_next;

    result_t            result_reg;
    logic               m_valid_reg;

    logic               accept;
    logic               pulse;
    logic               active;
    logic               expired;
    logic [SINCE_W-1:0] since_inc;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pulse    = s_tdata[0];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, result_reg};

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= CONFIRM_WINDOW_RST;
            duration_reg  <= ALARM_DURATION_RST;
            debounce_reg  <= DEBOUNCE_RST;
            threshold_reg <= THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                REG_CONFIRM_WINDOW: window_reg    <= cfg_wr_data;
                REG_ALARM_DURATION: duration_reg  <= cfg_wr_data;
                REG_DEBOUNCE:       debounce_reg  <= cfg_wr_data[SINCE_W-1:0];
                REG_THRESHOLD:      threshold_reg <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // one tick: expiry first, then the pulse
    always_comb begin
        since_inc    = (since_reg == SINCE_MAX) ? SINCE_MAX : since_reg + 1'b1;
        active       = (phase_reg == PH_WAIT) || (phase_reg == PH_ALARM);
        expired      = active && (timer_reg <= TIMER_W'(1));
        phase_next   = phase_reg;
        count_next   = count_reg;
        timer_next   = active ? timer_reg - 1'b1 : timer_reg;
        since_next   = since_inc;
        started_next = 1'b0;

        if (expired) begin
            if (phase_reg == PH_WAIT && count_reg >= threshold_reg) begin
                phase_next   = PH_ALARM;
                timer_next   = duration_reg;
                started_next = 1'b1;
            end else begin
                phase_next = PH_IDLE;
                timer_next = '0;
            end
            count_next = '0;
        end

        if (pulse && since_inc >= debounce_reg) begin
            since_next = '0;
            if (count_next != COUNT_MAX) begin
                count_next = count_next + 1'b1;
            end
            // code 3 is unreachable and would act as idle
            if (phase_next != PH_WAIT && phase_next != PH_ALARM) begin
                phase_next = PH_WAIT;
                timer_next = window_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            timer_reg   <= '0;
            since_reg   <= SINCE_MAX;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                timer_reg   <= timer_next;
                since_reg   <= since_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg.alarm_on       <= (phase_next == PH_ALARM);
            result_reg.phase          <= phase_next;
            result_reg.alarm_started  <= started_next;
            result_reg.pulses_counted <= count_next;
        end
    end

endmodule
